@@ sv/brd_pkg.sv @@
// ----------------------------------------------------------------------------
// brd_pkg
// Types and constants shared by the battery report decoder modules.
// ----------------------------------------------------------------------------
package brd_pkg;

    typedef struct packed {
        logic [4:0] report_length;
        logic [7:0] device_byte;
        logic [7:0] feature_byte;
        logic [7:0] function_byte;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [7:0] data_third;
    } report_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [6:0]  percent;
        logic [2:0]  power_status;
        logic [15:0] millivolts;
        logic [7:0]  error_code;
    } result_t;

    typedef struct packed {
        logic [7:0] expected_device;
        logic [7:0] expected_feature;
        logic [1:0] battery_kind;
    } cfg_t;

    // register indexes
    localparam logic [1:0] CFG_EXPECTED_DEVICE  = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_FEATURE = 2'd1;
    localparam logic [1:0] CFG_BATTERY_KIND     = 2'd2;

    // battery kinds
    localparam logic [1:0] KIND_LEVEL   = 2'd0;
    localparam logic [1:0] KIND_VOLTAGE = 2'd1;

    // outcomes
    localparam logic [2:0] OUTCOME_UNRELATED = 3'd0;
    localparam logic [2:0] OUTCOME_READING   = 3'd1;
    localparam logic [2:0] OUTCOME_SHORT     = 3'd2;
    localparam logic [2:0] OUTCOME_ERR10     = 3'd3;
    localparam logic [2:0] OUTCOME_ERR20     = 3'd4;

    // power status
    localparam logic [2:0] PWR_DISCHARGING  = 3'd0;
    localparam logic [2:0] PWR_CHARGING     = 3'd1;
    localparam logic [2:0] PWR_FULL         = 3'd2;
    localparam logic [2:0] PWR_NOT_CHARGING = 3'd3;
    localparam logic [2:0] PWR_UNKNOWN      = 3'd4;

    localparam logic [3:0] SOFTWARE_ID  = 4'hA;
    localparam logic [7:0] ERR_MARK_10  = 8'h8F;
    localparam logic [7:0] ERR_MARK_20  = 8'hFF;
    localparam logic [6:0] PERCENT_MAX  = 7'd100;
    localparam logic [4:0] LEN_MIN      = 5'd4;
    localparam logic [4:0] LEN_ERR_MIN  = 5'd6;
    localparam logic [4:0] LEN_FULL     = 5'd7;

    localparam int LUT_SIZE = 100;

    // discharge curve, millivolts at 100 % down to 1 %
    localparam logic [15:0] DISCHARGE_MV [LUT_SIZE] = '{
        16'd4186, 16'd4156, 16'd4143, 16'd4133, 16'd4122,
        16'd4113, 16'd4103, 16'd4094, 16'd4086, 16'd4075,
        16'd4067, 16'd4059, 16'd4051, 16'd4043, 16'd4035,
        16'd4027, 16'd4019, 16'd4011, 16'd4003, 16'd3997,
        16'd3989, 16'd3983, 16'd3976, 16'd3969, 16'd3961,
        16'd3955, 16'd3949, 16'd3942, 16'd3935, 16'd3929,
        16'd3922, 16'd3916, 16'd3909, 16'd3902, 16'd3896,
        16'd3890, 16'd3883, 16'd3877, 16'd3870, 16'd3865,
        16'd3859, 16'd3853, 16'd3848, 16'd3842, 16'd3837,
        16'd3833, 16'd3828, 16'd3824, 16'd3819, 16'd3815,
        16'd3811, 16'd3808, 16'd3804, 16'd3800, 16'd3797,
        16'd3793, 16'd3790, 16'd3787, 16'd3784, 16'd3781,
        16'd3778, 16'd3775, 16'd3772, 16'd3770, 16'd3767,
        16'd3764, 16'd3762, 16'd3759, 16'd3757, 16'd3754,
        16'd3751, 16'd3748, 16'd3744, 16'd3741, 16'd3737,
        16'd3734, 16'd3730, 16'd3726, 16'd3724, 16'd3720,
        16'd3717, 16'd3714, 16'd3710, 16'd3706, 16'd3702,
        16'd3697, 16'd3693, 16'd3688, 16'd3683, 16'd3677,
        16'd3671, 16'd3666, 16'd3662, 16'd3658, 16'd3654,
        16'd3646, 16'd3633, 16'd3612, 16'd3579, 16'd3537
    };

endpackage

@@ sv/brd_mv_percent.sv @@
// ----------------------------------------------------------------------------
// brd_mv_percent
// Converts millivolts to charge percent against the discharge curve.
// The curve falls strictly, so the percent is the count of points at or
// below the voltage.
// ----------------------------------------------------------------------------
module brd_mv_percent (
    input  logic [15:0] millivolts,
    output logic [6:0]  percent
);
    import brd_pkg::*;

    logic [LUT_SIZE-1:0] at_or_above;

    always_comb begin
        for (int i = 0; i < LUT_SIZE; i++) begin
            at_or_above[i] = (millivolts >= DISCHARGE_MV[i]);
        end
    end

    assign percent = 7'($countones(at_or_above));

endmodule

@@ sv/brd_classify.sv @@
// ----------------------------------------------------------------------------
// brd_classify
// Matches one report against the awaited request and decodes its fields.
// ----------------------------------------------------------------------------
module brd_classify (
    input  brd_pkg::report_t report,
    input  brd_pkg::cfg_t    cfg,
    output brd_pkg::result_t result
);
    import brd_pkg::*;

    logic [7:0]  req_func;
    logic [15:0] mv;
    logic [6:0]  mv_percent;
    logic        dev_match;
    logic        is_response;
    logic        is_error;
    logic        is_voltage;
    logic [2:0]  volt_status;
    logic [2:0]  lvl_status;

    assign req_func    = {3'b000, cfg.battery_kind[1], SOFTWARE_ID};
    assign mv          = {report.data_first, report.data_second};
    assign dev_match   = (report.device_byte == cfg.expected_device);
    assign is_voltage  = (cfg.battery_kind == KIND_VOLTAGE);
    assign is_response = (report.report_length >= LEN_MIN) && dev_match
                      && (report.feature_byte == cfg.expected_feature)
                      && (report.function_byte == req_func);
    assign is_error    = (report.report_length >= LEN_ERR_MIN) && dev_match
                      && ((report.feature_byte == ERR_MARK_10)
                          || (report.feature_byte == ERR_MARK_20))
                      && (report.function_byte == cfg.expected_feature)
                      && (report.data_first == req_func);

    brd_mv_percent u_mv_percent (
        .millivolts (mv),
        .percent    (mv_percent)
    );

    always_comb begin
        if (!report.data_third[7]) begin
            volt_status = PWR_DISCHARGING;
        end else begin
            case (report.data_third[2:0])
                3'd0:    volt_status = PWR_CHARGING;
                3'd1:    volt_status = PWR_FULL;
                3'd2:    volt_status = PWR_NOT_CHARGING;
                default: volt_status = PWR_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        case (report.data_third)
            8'd0:    lvl_status = PWR_DISCHARGING;
            8'd1:    lvl_status = PWR_CHARGING;
            8'd2:    lvl_status = PWR_CHARGING;
            8'd3:    lvl_status = PWR_FULL;
            8'd4:    lvl_status = (cfg.battery_kind == KIND_LEVEL) ? PWR_CHARGING
                                                                   : PWR_NOT_CHARGING;
            default: lvl_status = PWR_NOT_CHARGING;
        endcase
    end

    always_comb begin
        result.outcome      = OUTCOME_UNRELATED;
        result.percent      = '0;
        result.power_status = PWR_UNKNOWN;
        result.millivolts   = '0;
        result.error_code   = '0;
        if (is_response) begin
            if (report.report_length < LEN_FULL) begin
                result.outcome = OUTCOME_SHORT;
            end else begin
                result.outcome = OUTCOME_READING;
                if (is_voltage) begin
                    result.millivolts   = mv;
                    result.percent      = mv_percent;
                    result.power_status = volt_status;
                end else begin
                    result.percent      = (report.data_first > 8'(PERCENT_MAX))
                                        ? PERCENT_MAX : report.data_first[6:0];
                    result.power_status = lvl_status;
                end
            end
        end else if (is_error) begin
            result.outcome    = (report.feature_byte == ERR_MARK_10) ? OUTCOME_ERR10
                                                                     : OUTCOME_ERR20;
            result.error_code = report.data_second;
        end
    end

endmodule

@@ sv/battery_report_decoder.sv @@
// ----------------------------------------------------------------------------
// battery_report_decoder
// Classifies received battery reports against the awaited request.
//
// Input channel s_*: one report per transfer (length and bytes 1 to 6).
// Result channel m_*: exactly one result per report, in order.
// Configuration channel cfg_*: index 0 device, 1 feature, 2 battery kind;
//   index 3 is ignored. cfg_ready is always high; write only while idle.
// Path: each report is held in the input register, decoded, and its
//   result loaded into the result register, which drives m_valid.
// Throughput: one report per cycle while m_ready is high; the decode,
//   including the 100 parallel discharge curve compares, sits between
//   the input and result registers.
// Stall: when m_ready is low the result register holds and the input
//   register still takes one more report; s_ready drops only when both
//   registers are full.
// Reset: both registers empty, device 1, feature 0, level kind.
// ----------------------------------------------------------------------------
module battery_report_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brd_pkg::report_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output brd_pkg::result_t  m_payload,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import brd_pkg::*;

    cfg_t    cfg_reg;
    report_t in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t result_next;
    logic    out_free;
    logic    s_xfer;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_xfer    = s_valid && s_ready;
    assign advance   = in_valid_reg && out_free;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    brd_classify u_classify (
        .report (in_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_device  <= 8'd1;
            cfg_reg.expected_feature <= 8'd0;
            cfg_reg.battery_kind     <= KIND_LEVEL;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_EXPECTED_DEVICE:  cfg_reg.expected_device  <= cfg_data;
                CFG_EXPECTED_FEATURE: cfg_reg.expected_feature <= cfg_data;
                CFG_BATTERY_KIND:     cfg_reg.battery_kind     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (out_free) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

endmodule

@@ tb/battery_report_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_report_decoder_tb
// Self-checking bench for the battery report decoder. Directed reports cover
// level, unified and voltage readings, short and unrelated reports and both
// error markers. Random traffic then runs under several register settings,
// with and without idle cycles on either side. Every result is compared
// field by field against an in-bench decoder.
// ----------------------------------------------------------------------------
module battery_report_decoder_tb;

    import brd_pkg::*;

    localparam logic [1:0] KIND_UNIFIED  = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    // level status byte
    localparam logic [7:0] LVL_DISCHARGING = 8'd0;
    localparam logic [7:0] LVL_RECHARGING  = 8'd1;
    localparam logic [7:0] LVL_FINAL_STAGE = 8'd2;
    localparam logic [7:0] LVL_COMPLETE    = 8'd3;
    localparam logic [7:0] LVL_SLOW_CHARGE = 8'd4;

    // voltage charge flags
    localparam logic [7:0] VOLT_CHARGER_ON    = 8'h80;
    localparam logic [7:0] VOLT_STATE_MASK    = 8'h07;
    localparam logic [7:0] VOLT_CHARGING      = 8'h00;
    localparam logic [7:0] VOLT_FULL          = 8'h01;
    localparam logic [7:0] VOLT_NOT_CHARGING  = 8'h02;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PRINT_LIMIT    = 100;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEMS_PER_MODE = 45;
    localparam int EXPECT_DEPTH   = 2048;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    report_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    result_t  m_payload;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    logic [7:0] cfg_device  = 8'd1;
    logic [7:0] cfg_feature = 8'd0;
    logic [1:0] cfg_kind    = KIND_LEVEL;

    result_t predicted_results[EXPECT_DEPTH];
    int      expect_written = 0;
    int      expect_read    = 0;
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;

    battery_report_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] awaited_function();
        return {3'b000, cfg_kind >= KIND_UNIFIED, SOFTWARE_ID};
    endfunction

    function automatic result_t decode_report(input report_t r);
        result_t     res;
        logic [7:0]  want_func;
        logic [15:0] mv;
        want_func        = awaited_function();
        res.outcome      = OUTCOME_UNRELATED;
        res.percent      = '0;
        res.power_status = PWR_UNKNOWN;
        res.millivolts   = '0;
        res.error_code   = '0;
        if (r.report_length >= LEN_MIN && r.device_byte == cfg_device &&
            r.feature_byte == cfg_feature && r.function_byte == want_func) begin
            if (r.report_length < LEN_FULL) begin
                res.outcome = OUTCOME_SHORT;
            end else begin
                res.outcome = OUTCOME_READING;
                if (cfg_kind == KIND_VOLTAGE) begin
                    mv = {r.data_first, r.data_second};
                    res.millivolts = mv;
                    // keep the lowest table index whose voltage is reached
                    for (int i = LUT_SIZE - 1; i >= 0; i--) begin
                        if (mv >= DISCHARGE_MV[i])
                            res.percent = 7'(LUT_SIZE - i);
                    end
                    if ((r.data_third & VOLT_CHARGER_ON) == 8'h00) begin
                        res.power_status = PWR_DISCHARGING;
                    end else begin
                        case (r.data_third & VOLT_STATE_MASK)
                            VOLT_CHARGING:     res.power_status = PWR_CHARGING;
                            VOLT_FULL:         res.power_status = PWR_FULL;
                            VOLT_NOT_CHARGING: res.power_status = PWR_NOT_CHARGING;
                            default:           res.power_status = PWR_UNKNOWN;
                        endcase
                    end
                end else begin
                    res.percent = (r.data_first > PERCENT_MAX) ? PERCENT_MAX
                                                               : r.data_first[6:0];
                    case (r.data_third)
                        LVL_DISCHARGING: res.power_status = PWR_DISCHARGING;
                        LVL_RECHARGING,
                        LVL_FINAL_STAGE: res.power_status = PWR_CHARGING;
                        LVL_COMPLETE:    res.power_status = PWR_FULL;
                        LVL_SLOW_CHARGE: res.power_status = (cfg_kind == KIND_LEVEL) ?
                                                            PWR_CHARGING : PWR_NOT_CHARGING;
                        default:         res.power_status = PWR_NOT_CHARGING;
                    endcase
                end
            end
        end else if (r.report_length >= LEN_ERR_MIN && r.device_byte == cfg_device &&
                     (r.feature_byte == ERR_MARK_10 || r.feature_byte == ERR_MARK_20) &&
                     r.function_byte == cfg_feature && r.data_first == want_func) begin
            res.outcome    = (r.feature_byte == ERR_MARK_10) ? OUTCOME_ERR10 : OUTCOME_ERR20;
            res.error_code = r.data_second;
        end
        return res;
    endfunction

    function automatic report_t build_report(input logic [4:0] len, input logic [7:0] dev,
                                             input logic [7:0] feat, input logic [7:0] func,
                                             input logic [7:0] d1, input logic [7:0] d2,
                                             input logic [7:0] d3);
        return '{len, dev, feat, func, d1, d2, d3};
    endfunction

    function automatic report_t random_report();
        report_t     r;
        int          pick;
        int          idx;
        logic [15:0] mv;
        r.report_length = 5'($urandom_range(20));
        r.device_byte   = 8'($urandom);
        r.feature_byte  = 8'($urandom);
        r.function_byte = 8'($urandom);
        r.data_first    = 8'($urandom);
        r.data_second   = 8'($urandom);
        r.data_third    = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 50) begin
            r.report_length = ($urandom_range(9) == 0) ? 5'($urandom_range(6, 4))
                                                       : 5'($urandom_range(20, 7));
            r.device_byte   = cfg_device;
            r.feature_byte  = cfg_feature;
            r.function_byte = awaited_function();
            if (cfg_kind == KIND_VOLTAGE) begin
                case ($urandom_range(3))
                    0: mv = 16'($urandom);
                    1, 2: begin
                        idx = $urandom_range(LUT_SIZE - 1);
                        mv  = 16'(DISCHARGE_MV[idx] + $urandom_range(2) - 1);
                    end
                    default: mv = 16'($urandom_range(4400, 3400));
                endcase
                {r.data_first, r.data_second} = mv;
                r.data_third[7] = ($urandom_range(3) != 0);
            end else begin
                if ($urandom_range(1))
                    r.data_first = 8'($urandom_range(100));
                if ($urandom_range(3) != 0)
                    r.data_third = 8'($urandom_range(5));
            end
        end else if (pick < 70) begin
            r.report_length = ($urandom_range(7) == 0) ? 5'($urandom_range(5))
                                                       : 5'($urandom_range(20, 6));
            r.device_byte   = cfg_device;
            r.feature_byte  = $urandom_range(1) ? ERR_MARK_10 : ERR_MARK_20;
            r.function_byte = cfg_feature;
            r.data_first    = awaited_function();
        end else if (pick < 85) begin
            // near miss: flip one bit of one matched byte
            r.report_length = 5'($urandom_range(20, 7));
            r.device_byte   = cfg_device;
            r.feature_byte  = cfg_feature;
            r.function_byte = awaited_function();
            idx = $urandom_range(7);
            case ($urandom_range(2))
                0: r.device_byte[idx]   = ~r.device_byte[idx];
                1: r.feature_byte[idx]  = ~r.feature_byte[idx];
                default: r.function_byte[idx] = ~r.function_byte[idx];
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %0s mismatch, want %0h got %0h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expect_written == expect_read) begin
                report_mismatch("unrequested result", 16'h0, 16'(m_payload.outcome));
            end else begin
                want = predicted_results[11'(expect_read)];
                expect_read++;
                if (m_payload.outcome !== want.outcome)
                    report_mismatch("outcome", want.outcome, m_payload.outcome);
                if (m_payload.percent !== want.percent)
                    report_mismatch("percent", want.percent, m_payload.percent);
                if (m_payload.power_status !== want.power_status)
                    report_mismatch("power_status", want.power_status, m_payload.power_status);
                if (m_payload.millivolts !== want.millivolts)
                    report_mismatch("millivolts", want.millivolts, m_payload.millivolts);
                if (m_payload.error_code !== want.error_code)
                    report_mismatch("error_code", want.error_code, m_payload.error_code);
            end
        end
    end

    task automatic send_report(input report_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = r;
        do @(posedge aclk); while (!s_ready);
        predicted_results[11'(expect_written)] = decode_report(r);
        expect_written++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid = 1'b0;
        while (expect_written != expect_read)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_EXPECTED_DEVICE:  cfg_device  = value;
            CFG_EXPECTED_FEATURE: cfg_feature = value;
            CFG_BATTERY_KIND:     cfg_kind    = value[1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] dev, input logic [7:0] feat,
                                  input logic [1:0] kind);
        wait_for_results();
        write_register(CFG_EXPECTED_DEVICE, dev);
        write_register(CFG_EXPECTED_FEATURE, feat);
        write_register(CFG_BATTERY_KIND, {6'd0, kind});
    endtask

    // runs on the reset settings: device 1, feature 0, level kind
    task automatic test_level_reading();
        logic [7:0] f;
        f = awaited_function();
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, f, 8'hFF, 8'h00,
                                 LVL_DISCHARGING));
        send_report(build_report(5'd20, cfg_device, cfg_feature, f, 8'd100, 8'hFF,
                                 LVL_RECHARGING));
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, f, 8'd99, 8'h00,
                                 LVL_FINAL_STAGE));
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, f, 8'd0, 8'h00,
                                 LVL_COMPLETE));
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, f, 8'd101, 8'h00,
                                 LVL_SLOW_CHARGE));
        send_report(build_report(5'd20, cfg_device, cfg_feature, f, 8'd50, 8'h00, 8'hFF));
    endtask

    task automatic test_short_reports();
        logic [7:0] f;
        f = awaited_function();
        send_report(build_report(LEN_MIN, cfg_device, cfg_feature, f, 8'd50, 8'h00, 8'h00));
        send_report(build_report(LEN_ERR_MIN, cfg_device, cfg_feature, f, 8'd50, 8'h00, 8'h00));
        send_report(build_report(LEN_MIN - 5'd1, cfg_device, cfg_feature, f, 8'd50, 8'h00,
                                 8'h00));
        send_report(build_report(LEN_FULL, ~cfg_device, cfg_feature, f, 8'd50, 8'h00, 8'h00));
    endtask

    task automatic test_error_reports();
        logic [7:0] f;
        f = awaited_function();
        send_report(build_report(LEN_ERR_MIN, cfg_device, ERR_MARK_10, cfg_feature, f,
                                 8'hFF, 8'h00));
        send_report(build_report(LEN_ERR_MIN - 5'd1, cfg_device, ERR_MARK_20, cfg_feature, f,
                                 8'h05, 8'h00));
        send_report(build_report(5'd20, cfg_device, ERR_MARK_20, cfg_feature, f,
                                 8'h00, 8'hFF));
        send_report(build_report(LEN_FULL, cfg_device, ERR_MARK_20, cfg_feature, f ^ 8'h10,
                                 8'h01, 8'h00));
    endtask

    task automatic test_unified_kind();
        apply_settings(cfg_device, cfg_feature, KIND_UNIFIED);
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, awaited_function(),
                                 8'd42, 8'h00, LVL_SLOW_CHARGE));
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, {4'h0, SOFTWARE_ID},
                                 8'd42, 8'h00, LVL_COMPLETE));
        apply_settings(cfg_device, cfg_feature, KIND_RESERVED);
        send_report(build_report(LEN_FULL, cfg_device, cfg_feature, awaited_function(),
                                 8'd77, 8'h00, LVL_SLOW_CHARGE));
    endtask

    task automatic test_voltage_reading();
        logic [15:0] mv_points[6];
        logic [7:0]  flag_points[6];
        mv_points   = '{16'hFFFF, DISCHARGE_MV[0], DISCHARGE_MV[0] - 16'd1,
                        DISCHARGE_MV[LUT_SIZE - 1], DISCHARGE_MV[LUT_SIZE - 1] - 16'd1,
                        16'h0000};
        flag_points = '{8'h00, VOLT_CHARGER_ON | VOLT_CHARGING, VOLT_CHARGER_ON | VOLT_FULL,
                        VOLT_CHARGER_ON | VOLT_NOT_CHARGING, 8'h87, 8'h7F};
        apply_settings(cfg_device, cfg_feature, KIND_VOLTAGE);
        for (int i = 0; i < 6; i++)
            send_report(build_report(LEN_FULL, cfg_device, cfg_feature, awaited_function(),
                                     mv_points[i][15:8], mv_points[i][7:0], flag_points[i]));
    endtask

    task automatic test_random_traffic();
        logic [7:0] dev_list[8];
        logic [7:0] feat_list[8];
        logic [1:0] kind_list[8];
        int         send_modes[4];
        int         stall_modes[4];
        dev_list    = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'h01,
                        8'($urandom), 8'($urandom)};
        feat_list   = '{8'h00, 8'hFF, ERR_MARK_10, 8'($urandom), 8'($urandom), ERR_MARK_20,
                        8'h0A, 8'($urandom)};
        kind_list   = '{KIND_LEVEL, KIND_VOLTAGE, KIND_UNIFIED, KIND_RESERVED, KIND_VOLTAGE,
                        KIND_LEVEL, KIND_VOLTAGE, KIND_UNIFIED};
        send_modes  = '{0, 52, 0, 19};
        stall_modes = '{0, 0, 52, 19};
        wait_for_results();
        write_register(CFG_UNUSED, 8'($urandom));
        for (int s = 0; s < 8; s++) begin
            apply_settings(dev_list[s], feat_list[s], kind_list[s]);
            for (int p = 0; p < 4; p++) begin
                send_idle_pct = send_modes[p];
                stall_pct     = stall_modes[p];
                repeat (ITEMS_PER_MODE) send_report(random_report());
                // hold off until the block has emptied
                wait_for_results();
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_level_reading();
        test_short_reports();
        test_error_reports();
        test_unified_kind();
        test_voltage_reading();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
